// ===== design/rgble_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RGB LED line encoder: widths, timing register codes and reset values,
// the segment sequence limits and the structs passed between the top level and the
// serializer. No dependencies.
package rgble_pkg;

    localparam int CHAN_W    = 8;
    localparam int DUR_W     = 16;
    localparam int NUM_CHAN  = 3;
    localparam int PIXEL_W   = NUM_CHAN * CHAN_W;
    localparam int CFG_IDX_W = 3;
    localparam int SEG_W     = 6;

    // Segment numbers within one pixel: two per data bit, then the optional latch.
    localparam logic [SEG_W-1:0] LAST_DATA_SEG = SEG_W'(2 * PIXEL_W - 1);
    localparam logic [SEG_W-1:0] LATCH_SEG     = SEG_W'(2 * PIXEL_W);

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_ZERO_HIGH = 3'd2,
        CFG_ZERO_LOW  = 3'd3,
        CFG_LATCH     = 3'd4
    } t_cfg_reg;

    localparam logic [DUR_W-1:0] RST_ONE_HIGH  = 16'd13;
    localparam logic [DUR_W-1:0] RST_ONE_LOW   = 16'd7;
    localparam logic [DUR_W-1:0] RST_ZERO_HIGH = 16'd6;
    localparam logic [DUR_W-1:0] RST_ZERO_LOW  = 16'd14;
    localparam logic [DUR_W-1:0] RST_LATCH     = 16'd880;

    // Segment lengths as driven; a programmed zero is stored as one.
    typedef struct packed {
        logic [DUR_W-1:0] one_high;
        logic [DUR_W-1:0] one_low;
        logic [DUR_W-1:0] zero_high;
        logic [DUR_W-1:0] zero_low;
        logic [DUR_W-1:0] latch;
    } t_timing;

    // One scaled pixel, green in the top byte so it goes out first.
    typedef struct packed {
        logic [PIXEL_W-1:0] bits;
        logic               latch;
    } t_pixel_word;

endpackage

// ===== design/rgble_lane.sv =====
`timescale 1ns / 1ps
// One color lane: scales a channel by the brightness as channel*brightness/255,
// truncating, over two register stages. Depends on rgble_pkg.
module rgble_lane (
    input  logic                         i_clk,
    input  logic                         i_en_mul,
    input  logic                         i_en_div,
    input  logic [rgble_pkg::CHAN_W-1:0] i_chan,
    input  logic [rgble_pkg::CHAN_W-1:0] i_bri,
    output logic [rgble_pkg::CHAN_W-1:0] o_scaled
);

    logic [2*rgble_pkg::CHAN_W-1:0] r_prod;
    logic [rgble_pkg::CHAN_W-1:0]   r_quot;
    logic [2*rgble_pkg::CHAN_W:0]   n_sum;

    // For a 16-bit x, x/255 equals (x + (x >> 8) + 1) >> 8.
    assign n_sum = {1'b0, r_prod} + (2*rgble_pkg::CHAN_W+1)'(r_prod[15:8])
                   + (2*rgble_pkg::CHAN_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_prod <= i_chan * i_bri;
        end
        if (i_en_div) begin
            r_quot <= n_sum[15:8];
        end
    end

    assign o_scaled = r_quot;

endmodule

// ===== design/rgble_ser.sv =====
`timescale 1ns / 1ps
// Segment serializer: takes the merged pixel word and emits one line segment per
// cycle while m_axis is not stalled, through a registered stream output. Depends on rgble_pkg.
module rgble_ser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load_valid,
    input  rgble_pkg::t_pixel_word          i_word,
    output logic                            o_load_ready,
    input  rgble_pkg::t_timing              i_timing,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rgble_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [0] line_level, [16:1] duration
    output logic                            m_axis_tlast    // last_segment
);

    logic                            r_busy;
    logic [rgble_pkg::SEG_W-1:0]     r_seg;
    logic [rgble_pkg::PIXEL_W-1:0]   r_bits;
    logic                            r_latch;
    logic                            r_ov;
    logic                            r_level;
    logic [rgble_pkg::DUR_W-1:0]     r_dur;
    logic                            r_last;

    logic                            n_fire;
    logic                            n_gen_last;
    logic                            n_in_latch;
    logic                            n_bit;
    logic                            n_level;
    logic [rgble_pkg::DUR_W-1:0]     n_dur;
    logic                            n_load;

    assign n_in_latch = (r_seg == rgble_pkg::LATCH_SEG);
    assign n_gen_last = r_latch ? n_in_latch : (r_seg == rgble_pkg::LAST_DATA_SEG);
    assign n_bit      = r_bits[rgble_pkg::PIXEL_W-1];
    assign n_level    = !r_seg[0] && !n_in_latch;

    always_comb begin
        if (n_in_latch) begin
            n_dur = i_timing.latch;
        end else if (!r_seg[0]) begin
            n_dur = n_bit ? i_timing.one_high : i_timing.zero_high;
        end else begin
            n_dur = n_bit ? i_timing.one_low : i_timing.zero_low;
        end
    end

    assign n_fire       = r_busy && (!r_ov || m_axis_tready);
    assign o_load_ready = !r_busy || (n_fire && n_gen_last);
    assign n_load       = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (n_load) begin
                r_busy <= 1'b1;
                r_seg  <= '0;
            end else if (n_fire) begin
                if (n_gen_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_seg <= r_seg + rgble_pkg::SEG_W'(1);
                end
            end
            if (n_fire) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_bits  <= i_word.bits;
            r_latch <= i_word.latch;
        end else if (n_fire && r_seg[0]) begin
            r_bits <= {r_bits[rgble_pkg::PIXEL_W-2:0], 1'b0};
        end
        if (n_fire) begin
            r_level <= n_level;
            r_dur   <= n_dur;
            r_last  <= n_gen_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(rgble_pkg::M_TDATA_W-rgble_pkg::DUR_W-1){1'b0}}, r_dur, r_level};
    assign m_axis_tlast  = r_last;

endmodule

// ===== design/rgb_led_line_encoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the RGB LED line encoder: timing registers, three scaling lanes, the
// merge into one green-red-blue word and the segment serializer.
// Depends on rgble_pkg, rgble_lane and rgble_ser.
//
//  Channel  | Direction | Handshake                    | Word
//  ---------+-----------+------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | pixel: red, green, blue, bright
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | segment: level, duration
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | timing register index and value
//
// Each pixel yields 48 segment words, or 49 when tlast marks the end of a frame, one word
// per cycle unless m_axis stalls. The first segment of a pixel passes the divide correction,
// the serializer load and the output register; the next pixel loads as the last word of
// the previous one is produced, so the words of consecutive pixels leave back to back.
// A stall on m_axis freezes the serializer; once both lane stages hold a pixel, the input
// stalls. Synchronous active-low reset restores the timing defaults and empties the pipeline.
module rgb_led_line_encoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel input.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rgble_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] red, [15:8] green,
                                                             // [23:16] blue, [31:24] brightness
    input  logic                              s_axis_tlast,  // frame_end
    // Segment output.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [rgble_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // [0] line_level, [16:1] duration
    output logic                              m_axis_tlast,  // last_segment
    // Timing register writes.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rgble_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rgble_pkg::DUR_W-1:0]       i_cfg_data
);

    rgble_pkg::t_timing     r_timing;
    rgble_pkg::t_pixel_word n_word;

    logic                           r_s1_v;
    logic                           r_s2_v;
    logic                           r_s1_latch;
    logic                           r_s2_latch;
    logic                           n_en1;
    logic                           n_en2;
    logic                           n_load_ready;
    logic [rgble_pkg::DUR_W-1:0]    n_cfg_len;
    logic [rgble_pkg::CHAN_W-1:0]   n_scaled [rgble_pkg::NUM_CHAN];

    // ---------------------------------------------------------------- configuration
    // A zero length is stored as one, so no segment has zero length.
    // The config port is always ready.
    assign o_cfg_ready = 1'b1;
    assign n_cfg_len   = (i_cfg_data == '0) ? rgble_pkg::DUR_W'(1) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.one_high  <= rgble_pkg::RST_ONE_HIGH;
            r_timing.one_low   <= rgble_pkg::RST_ONE_LOW;
            r_timing.zero_high <= rgble_pkg::RST_ZERO_HIGH;
            r_timing.zero_low  <= rgble_pkg::RST_ZERO_LOW;
            r_timing.latch     <= rgble_pkg::RST_LATCH;
        end else if (i_cfg_valid) begin
            case (rgble_pkg::t_cfg_reg'(i_cfg_index))
                rgble_pkg::CFG_ONE_HIGH:  r_timing.one_high  <= n_cfg_len;
                rgble_pkg::CFG_ONE_LOW:   r_timing.one_low   <= n_cfg_len;
                rgble_pkg::CFG_ZERO_HIGH: r_timing.zero_high <= n_cfg_len;
                rgble_pkg::CFG_ZERO_LOW:  r_timing.zero_low  <= n_cfg_len;
                rgble_pkg::CFG_LATCH:     r_timing.latch     <= n_cfg_len;
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- lane pipeline
    // Stage one holds the products, stage two the quotients. Each stage advances when
    // it is empty or when the stage after it takes its word.
    assign n_en2         = !r_s2_v || n_load_ready;
    assign n_en1         = !r_s1_v || n_en2;
    assign s_axis_tready = n_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (n_en1) begin
                r_s1_v <= s_axis_tvalid;
            end
            if (n_en2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en1) begin
            r_s1_latch <= s_axis_tlast;
        end
        if (n_en2) begin
            r_s2_latch <= r_s1_latch;
        end
    end

    // Lane 0 red, lane 1 green, lane 2 blue, all scaled by the same brightness.
    for (genvar g = 0; g < rgble_pkg::NUM_CHAN; g++) begin : g_lane
        rgble_lane u_lane (
            .i_clk    (i_clk),
            .i_en_mul (n_en1),
            .i_en_div (n_en2),
            .i_chan   (s_axis_tdata[g*rgble_pkg::CHAN_W +: rgble_pkg::CHAN_W]),
            .i_bri    (s_axis_tdata[rgble_pkg::NUM_CHAN*rgble_pkg::CHAN_W +:
                                    rgble_pkg::CHAN_W]),
            .o_scaled (n_scaled[g])
        );
    end

    // Merge: green goes out first, then red, then blue, each most significant bit first.
    assign n_word.bits  = {n_scaled[1], n_scaled[0], n_scaled[2]};
    assign n_word.latch = r_s2_latch;

    // ---------------------------------------------------------------- serializer
    rgble_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load_valid  (r_s2_v),
        .i_word        (n_word),
        .o_load_ready  (n_load_ready),
        .i_timing      (r_timing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ---------------------------------------------------------------- checks
    // A pixel waiting in the second stage is not dropped while the serializer is busy.
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !n_load_ready |=> r_s2_v)
        else $error("pixel lost in lane output stage");

    // The final segment of a pixel always leaves the line low.
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[0])
        else $error("final segment drives the line high");

    // No segment has zero length.
    a_dur_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[rgble_pkg::DUR_W:1] != '0)
        else $error("zero length segment");

endmodule

// ===== tb/sv/rgb_led_line_encoder_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rgb_led_line_encoder_top: pixels in, line segments out,
// each segment compared with a local encoder model. Depends on rgble_pkg and the top level.
module rgb_led_line_encoder_top_test;

    localparam int CLK_HALF     = 10;
    localparam int IDLE_PCT     = 26;   // chance in percent that a side idles in a cycle
    localparam int HOLD_CYCLES  = 400;  // long receiver stall that backs up the pipeline
    localparam int DRAIN_PAD    = 8;    // cycles after the last segment, above the latency
    localparam int FULL_SCALE   = 255;  // brightness that leaves a channel unscaled
    localparam int RAND_PHASES  = 5;
    localparam int RAND_PER_PHS = 48;

    // Register indexes above the last timing register are decoded as nothing.
    localparam int CFG_SPARE_FIRST = int'(rgble_pkg::CFG_LATCH) + 1;
    localparam int CFG_IDX_COUNT   = 1 << rgble_pkg::CFG_IDX_W;

    typedef struct packed {
        logic [rgble_pkg::CHAN_W-1:0] red;
        logic [rgble_pkg::CHAN_W-1:0] green;
        logic [rgble_pkg::CHAN_W-1:0] blue;
        logic [rgble_pkg::CHAN_W-1:0] bright;
        logic                         frame_end;
    } t_pixel;

    typedef struct packed {
        logic                        level;
        logic [rgble_pkg::DUR_W-1:0] duration;
        logic                        last;
    } t_segment;

    // All inputs of the block start at a known value.
    logic                              i_clk         = 1'b0;
    logic                              i_rst_n       = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [rgble_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                              s_axis_tlast  = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [rgble_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                              m_axis_tlast;
    logic                              i_cfg_valid   = 1'b0;
    logic                              o_cfg_ready;
    logic [rgble_pkg::CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [rgble_pkg::DUR_W-1:0]       i_cfg_data    = '0;

    // Local copy of the timing registers, as written (a zero stays a zero here).
    logic [rgble_pkg::DUR_W-1:0] model_one_high  = rgble_pkg::RST_ONE_HIGH;
    logic [rgble_pkg::DUR_W-1:0] model_one_low   = rgble_pkg::RST_ONE_LOW;
    logic [rgble_pkg::DUR_W-1:0] model_zero_high = rgble_pkg::RST_ZERO_HIGH;
    logic [rgble_pkg::DUR_W-1:0] model_zero_low  = rgble_pkg::RST_ZERO_LOW;
    logic [rgble_pkg::DUR_W-1:0] model_latch     = rgble_pkg::RST_LATCH;

    t_pixel   pixels_pending [$];
    t_segment segments_due   [$];
    t_pixel   pixel_on_bus;

    bit burst_mode    = 1'b0;  // both sides busy every cycle
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int pixels_taken  = 0;
    int frames_closed = 0;
    int segments_seen = 0;
    int settings_used = 0;

    rgb_led_line_encoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------------------
    // Encoder model
    // ------------------------------------------------------------------------------------

    // Channel times brightness over full scale, truncated.
    function automatic logic [rgble_pkg::CHAN_W-1:0] scale_chan(
        logic [rgble_pkg::CHAN_W-1:0] ch, logic [rgble_pkg::CHAN_W-1:0] br);
        logic [2*rgble_pkg::CHAN_W-1:0] prod;
        prod = ch * br;
        return rgble_pkg::CHAN_W'(prod / FULL_SCALE);
    endfunction

    // A register left at zero still drives a one-cycle segment.
    function automatic logic [rgble_pkg::DUR_W-1:0] drive_len(logic [rgble_pkg::DUR_W-1:0] r);
        return (r == '0) ? rgble_pkg::DUR_W'(1) : r;
    endfunction

    // Queues the segments one pixel produces: green, red, blue, each MSB first, two
    // segments per bit, and a low latch segment when the pixel closes a frame.
    function automatic void encode_pixel(t_pixel px);
        logic [rgble_pkg::CHAN_W-1:0] sent [rgble_pkg::NUM_CHAN];
        logic                         one;
        logic                         closing;
        sent[0] = scale_chan(px.green, px.bright);
        sent[1] = scale_chan(px.red, px.bright);
        sent[2] = scale_chan(px.blue, px.bright);
        for (int c = 0; c < rgble_pkg::NUM_CHAN; c++) begin
            for (int i = rgble_pkg::CHAN_W - 1; i >= 0; i--) begin
                one     = sent[c][i];
                closing = (c == rgble_pkg::NUM_CHAN - 1) && (i == 0) && !px.frame_end;
                segments_due.push_back('{1'b1,
                    drive_len(one ? model_one_high : model_zero_high), 1'b0});
                segments_due.push_back('{1'b0,
                    drive_len(one ? model_one_low : model_zero_low), closing});
            end
        end
        if (px.frame_end)
            segments_due.push_back('{1'b0, drive_len(model_latch), 1'b1});
    endfunction

    // ------------------------------------------------------------------------------------
    // Pixel driver: takes words from the pending queue, idles at random outside bursts.
    // The model runs at the edge where the block accepts the word.
    // ------------------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_pixels
        t_pixel nxt;
        if (s_axis_tvalid && s_axis_tready) begin
            encode_pixel(pixel_on_bus);
            pixels_taken++;
            if (pixel_on_bus.frame_end)
                frames_closed++;
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (pixels_pending.size() != 0 &&
                (burst_mode || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = pixels_pending.pop_front();
                pixel_on_bus  <= nxt;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.bright, nxt.blue, nxt.green, nxt.red};
                s_axis_tlast  <= nxt.frame_end;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Segment receiver: random back-pressure, plus a long stall whenever one is requested.
    // While stalled the sender keeps offering, so the lane stages fill and the input stops.
    // ------------------------------------------------------------------------------------
    always @(posedge i_clk) begin : pace_segments
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_done != hold_requests) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            holds_done    <= holds_done + 1;
        end else begin
            m_axis_tready <= burst_mode || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Segment checker: each accepted word against the oldest expected segment.
    always @(posedge i_clk) begin : check_segments
        t_segment want;
        t_segment got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[0], m_axis_tdata[rgble_pkg::DUR_W:1], m_axis_tlast};
            if (segments_due.size() == 0) begin
                fail_count++;
                $display("%0t: expected no segment, got level %0b duration %0d last %0b",
                         $realtime, got.level, got.duration, got.last);
            end else begin
                want = segments_due.pop_front();
                if (got !== want) begin
                    fail_count++;
                    $display("%0t: segment %0d expected %0b/%0d/%0b, got %0b/%0d/%0b",
                             $realtime, segments_seen, want.level, want.duration,
                             want.last, got.level, got.duration, got.last);
                end
            end
            segments_seen++;
        end
    end

    // ------------------------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------------------------

    // Writes one timing register; called at a clock edge, returns at the accepting edge
    // with the write still offered, so back-to-back writes need no gap.
    task automatic write_reg(logic [rgble_pkg::CFG_IDX_W-1:0] idx,
                             logic [rgble_pkg::DUR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (rgble_pkg::t_cfg_reg'(idx))
            rgble_pkg::CFG_ONE_HIGH:  model_one_high  = val;
            rgble_pkg::CFG_ONE_LOW:   model_one_low   = val;
            rgble_pkg::CFG_ZERO_HIGH: model_zero_high = val;
            rgble_pkg::CFG_ZERO_LOW:  model_zero_low  = val;
            rgble_pkg::CFG_LATCH:     model_latch     = val;
            default: ;  // unused index, the block must ignore it
        endcase
    endtask

    // Loads all five timing registers, then pokes the unused indexes with noise.
    task automatic load_timing(logic [rgble_pkg::DUR_W-1:0] oh, logic [rgble_pkg::DUR_W-1:0] ol,
                               logic [rgble_pkg::DUR_W-1:0] zh, logic [rgble_pkg::DUR_W-1:0] zl,
                               logic [rgble_pkg::DUR_W-1:0] lt);
        write_reg(rgble_pkg::CFG_ONE_HIGH, oh);
        write_reg(rgble_pkg::CFG_ONE_LOW, ol);
        write_reg(rgble_pkg::CFG_ZERO_HIGH, zh);
        write_reg(rgble_pkg::CFG_ZERO_LOW, zl);
        write_reg(rgble_pkg::CFG_LATCH, lt);
        for (int k = CFG_SPARE_FIRST; k < CFG_IDX_COUNT; k++)
            write_reg(rgble_pkg::CFG_IDX_W'(k), rgble_pkg::DUR_W'($urandom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Returns at a clock edge once every pixel is taken and every segment has come out.
    task automatic wait_drained();
        while (pixels_pending.size() != 0 || s_axis_tvalid || segments_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic add_pixel(logic [rgble_pkg::CHAN_W-1:0] r, logic [rgble_pkg::CHAN_W-1:0] g,
                             logic [rgble_pkg::CHAN_W-1:0] b, logic [rgble_pkg::CHAN_W-1:0] br,
                             logic fe);
        pixels_pending.push_back('{r, g, b, br, fe});
    endtask

    // Mostly arbitrary lengths, with zero, one and full scale mixed in.
    function automatic logic [rgble_pkg::DUR_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return rgble_pkg::DUR_W'(1);
            2:       return '1;
            default: return rgble_pkg::DUR_W'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic add_random_pixels(int count);
        logic [rgble_pkg::CHAN_W-1:0] br;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1:    br = '1;
                2:       br = '0;
                default: br = rgble_pkg::CHAN_W'($urandom);
            endcase
            add_pixel(rgble_pkg::CHAN_W'($urandom), rgble_pkg::CHAN_W'($urandom),
                      rgble_pkg::CHAN_W'($urandom), br, $urandom_range(0, 4) == 0);
        end
    endtask

    initial begin : run_phases
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset timing: channel and brightness extremes, single bits, frame ends.
        add_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1);
        add_pixel(8'h80, 8'h01, 8'h80, 8'hFF, 1'b0);
        add_pixel(8'hAA, 8'h55, 8'hAA, 8'hFF, 1'b1);
        add_pixel(8'h55, 8'hAA, 8'h55, 8'hFF, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0);  // scales to one
        add_pixel(8'hFE, 8'hFF, 8'h01, 8'hFE, 1'b0);  // truncation just below full
        add_pixel(8'hFF, 8'h00, 8'hFF, 8'h80, 1'b1);
        add_pixel(8'h01, 8'h02, 8'h04, 8'hFF, 1'b0);
        add_pixel(8'h10, 8'h20, 8'h40, 8'h7F, 1'b1);
        add_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
        wait_drained();

        // Shortest lengths everywhere.
        load_timing('d1, 'd1, 'd1, 'd1, 'd1);
        add_pixel(8'hA5, 8'h5A, 8'hC3, 8'hFF, 1'b1);
        add_pixel(8'h3C, 8'hFF, 8'h00, 8'hFF, 1'b0);
        add_pixel(8'hFF, 8'h81, 8'h7E, 8'hC0, 1'b1);
        wait_drained();

        // Longest lengths everywhere.
        load_timing('1, '1, '1, '1, '1);
        add_pixel(8'hF0, 8'h0F, 8'hCC, 8'hFF, 1'b1);
        add_pixel(8'h33, 8'hFF, 8'h99, 8'hE0, 1'b0);
        add_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        wait_drained();

        // Registers holding zero must still drive one-cycle segments.
        load_timing('0, '0, '0, '0, '0);
        add_pixel(8'h96, 8'h69, 8'hF0, 8'hFF, 1'b1);
        add_pixel(8'hFF, 8'h00, 8'h80, 8'hFF, 1'b0);
        add_pixel(8'h12, 8'h34, 8'h56, 8'h9A, 1'b1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            load_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
            case (p)
                1: begin
                    // No idling on either side, with a long stall on the output first.
                    burst_mode = 1'b1;
                    hold_requests++;
                    add_random_pixels(RAND_PER_PHS);
                    wait_drained();
                    burst_mode = 1'b0;
                end
                3: begin
                    // The sender stops halfway until the block has fully drained.
                    add_random_pixels(RAND_PER_PHS / 2);
                    wait_drained();
                    add_random_pixels(RAND_PER_PHS - RAND_PER_PHS / 2);
                    wait_drained();
                end
                default: begin
                    add_random_pixels(RAND_PER_PHS);
                    wait_drained();
                end
            endcase
        end

        $display("Encoded %0d pixels (%0d closing a frame) into %0d segments",
                 pixels_taken, frames_closed, segments_seen);
        $display("under %0d timing register settings besides the reset values",
                 settings_used);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial begin : watchdog
        #20_000_000;
        $display("Timed out with %0d segments still expected", segments_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/rgble_pkg.sv
design/rgble_lane.sv
design/rgble_ser.sv
design/rgb_led_line_encoder_top.sv
tb/sv/rgb_led_line_encoder_top_test.sv
